// File: rtl/core/multichannel_biquad_filter_assert.svh
// Assertion macros for the multichannel biquad filter.
// Included by the top level; no other dependencies.
`ifndef MULTICHANNEL_BIQUAD_FILTER_ASSERT_SVH
`define MULTICHANNEL_BIQUAD_FILTER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define MBQ_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define MBQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/mbq_pkg.sv
// Shared types, constants, microcode program and saturating arithmetic
// for the multichannel biquad filter. No dependencies.
package mbq_pkg;

    localparam int MAX_CHANNELS_DEF = 16;
    localparam int SAMPLE_BITS_DEF  = 24;
    localparam int COEF_BITS_DEF    = 24;
    localparam int DELAY_BITS       = 32;
    localparam int ACC_BITS         = 64;
    localparam int CH_BITS          = 4;
    localparam int CH_USE_BITS      = 5;
    localparam int CFG_ADDR_W       = 3;
    localparam int NUM_REGS         = 6;
    localparam int STEP_W           = 3;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_B0     = 3'd0,
        REG_B1     = 3'd1,
        REG_B2     = 3'd2,
        REG_A1     = 3'd3,
        REG_A2     = 3'd4,
        REG_CH_USE = 3'd5
    } reg_idx_t;

    // Multiplier coefficient operand
    typedef enum logic [2:0] {
        CS_B0 = 3'd0,
        CS_B1 = 3'd1,
        CS_B2 = 3'd2,
        CS_A1 = 3'd3,
        CS_A2 = 3'd4
    } coef_sel_t;

    // Multiplier data operand
    typedef enum logic [1:0] {
        DS_D1 = 2'd0,
        DS_D2 = 2'd1,
        DS_W  = 2'd2
    } data_sel_t;

    // Accumulator operation
    typedef enum logic [2:0] {
        ACC_HOLD   = 3'd0,
        ACC_LOAD_X = 3'd1,
        ACC_SUB_P  = 3'd2,
        ACC_ADD_P  = 3'd3,
        ACC_LOAD_P = 3'd4
    } acc_op_t;

    // One microcode control word
    typedef struct packed {
        coef_sel_t         coef_sel;
        data_sel_t         data_sel;
        acc_op_t           acc_op;
        logic              w_ld;
        logic              mem_wr;
        logic              out_ld;
        logic              jmp_err;
        logic [STEP_W-1:0] jmp_to;
        logic              last;
    } ucode_t;

    // Sequencer to datapath control
    typedef struct packed {
        ucode_t uc;
        logic   en;
    } seq_ctl_t;

    localparam logic [STEP_W-1:0] STEP_OUT = 3'd6;

    // Microcode program: feedback MACs, round w, feedforward MACs, round y
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        w = '0;
        unique case (step)
            3'd0: begin
                w.coef_sel = CS_A1;
                w.data_sel = DS_D1;
                w.acc_op   = ACC_LOAD_X;
                w.jmp_err  = 1'b1;
                w.jmp_to   = STEP_OUT;
            end
            3'd1: begin
                w.coef_sel = CS_A2;
                w.data_sel = DS_D2;
                w.acc_op   = ACC_SUB_P;
            end
            3'd2: begin
                w.coef_sel = CS_B1;
                w.data_sel = DS_D1;
                w.acc_op   = ACC_SUB_P;
            end
            3'd3: begin
                w.coef_sel = CS_B2;
                w.data_sel = DS_D2;
                w.acc_op   = ACC_LOAD_P;
                w.w_ld     = 1'b1;
            end
            3'd4: begin
                w.coef_sel = CS_B0;
                w.data_sel = DS_W;
                w.acc_op   = ACC_ADD_P;
                w.mem_wr   = 1'b1;
            end
            3'd5: begin
                w.acc_op   = ACC_ADD_P;
            end
            3'd6: begin
                w.out_ld   = 1'b1;
                w.last     = 1'b1;
            end
            default: begin
                w.last     = 1'b1;
            end
        endcase
        return w;
    endfunction

    // Add or subtract with saturation at the accumulator limits
    function automatic logic signed [ACC_BITS-1:0] sat_addsub(
        input logic signed [ACC_BITS-1:0] a,
        input logic signed [ACC_BITS-1:0] b,
        input logic                       sub
    );
        logic [ACC_BITS:0]       s;
        logic [ACC_BITS-1:0]     r;
        if (sub) begin
            s = {a[ACC_BITS-1], a} - {b[ACC_BITS-1], b};
        end else begin
            s = {a[ACC_BITS-1], a} + {b[ACC_BITS-1], b};
        end
        if (s[ACC_BITS] != s[ACC_BITS-1]) begin
            r = s[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}} : {1'b0, {(ACC_BITS-1){1'b1}}};
        end else begin
            r = s[ACC_BITS-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/core/mbq_seq.sv
// Microcode sequencer: step counter, program fetch and conditional jump.
// Depends on mbq_pkg.
module mbq_seq
    import mbq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     start,
    input  logic     err,
    input  logic     out_busy,
    output seq_ctl_t ctl,
    output logic     busy
);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    ucode_t            uc;
    logic              en;

    // Fetch the control word and hold on a blocked result load
    always_comb begin
        uc  = ucode_rom(step_reg);
        en  = busy_reg && !(uc.out_ld && out_busy);
        ctl = '{uc: uc, en: en};
    end

    // Advance, jump or finish
    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        priority if (start) begin
            busy_next = 1'b1;
            step_next = '0;
        end else if (en && uc.last) begin
            busy_next = 1'b0;
        end else if (en && uc.jmp_err && err) begin
            step_next = uc.jmp_to;
        end else if (en) begin
            step_next = step_reg + STEP_W'(1);
        end else begin
            step_next = step_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    assign busy = busy_reg;

endmodule

// File: rtl/core/mbq_delay_ram.sv
// Per-channel delay memory (d1, d2 in one row) with registered read and
// valid bits that clear at reset and on a configuration write. Depends on mbq_pkg.
module mbq_delay_ram
    import mbq_pkg::*;
#(
    parameter int DEPTH  = MAX_CHANNELS_DEF,
    parameter int ADDR_W = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         clear,
    input  logic                         rd_en,
    input  logic [ADDR_W-1:0]            rd_addr,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic signed [DELAY_BITS-1:0] wr_d1,
    input  logic signed [DELAY_BITS-1:0] wr_d2,
    output logic signed [DELAY_BITS-1:0] rd_d1,
    output logic signed [DELAY_BITS-1:0] rd_d2
);

    logic [2*DELAY_BITS-1:0] mem [DEPTH];
    logic [DEPTH-1:0]        valid_reg;
    logic [2*DELAY_BITS-1:0] rd_row_reg;
    logic                    rd_vld_reg;

    // Write a row
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_d2, wr_d1};
        end
    end

    // Mark written rows; drop all on reset or clear
    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Registered read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_row_reg <= mem[rd_addr];
            rd_vld_reg <= valid_reg[rd_addr];
        end
    end

    // A row never written since the last clear reads as zero
    assign rd_d1 = rd_vld_reg ? rd_row_reg[DELAY_BITS-1:0] : '0;
    assign rd_d2 = rd_vld_reg ? rd_row_reg[2*DELAY_BITS-1:DELAY_BITS] : '0;

endmodule

// File: rtl/core/mbq_datapath.sv
// Shared multiplier, saturating accumulator and rounding unit, driven by
// the sequencer's control word. Depends on mbq_pkg.
module mbq_datapath
    import mbq_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = COEF_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          in_ld,
    input  logic signed [SAMPLE_BITS-1:0] x_in,
    input  logic signed [COEF_BITS-1:0]   b0,
    input  logic signed [COEF_BITS-1:0]   b1,
    input  logic signed [COEF_BITS-1:0]   b2,
    input  logic signed [COEF_BITS-1:0]   a1,
    input  logic signed [COEF_BITS-1:0]   a2,
    input  seq_ctl_t                      ctl,
    input  logic signed [DELAY_BITS-1:0]  d1,
    input  logic signed [DELAY_BITS-1:0]  d2,
    output logic signed [DELAY_BITS-1:0]  w_out,
    output logic signed [SAMPLE_BITS-1:0] y_out
);

    localparam int CFRAC  = COEF_BITS - 3;
    localparam int PROD_W = COEF_BITS + DELAY_BITS;
    localparam logic signed [ACC_BITS-1:0] RND_BIAS = ACC_BITS'(1) <<< (CFRAC - 1);
    localparam logic signed [ACC_BITS-1:0] W_MAX =
        (ACC_BITS'(1) <<< (DELAY_BITS - 1)) - ACC_BITS'(1);
    localparam logic signed [ACC_BITS-1:0] W_MIN = ~W_MAX;
    localparam logic signed [ACC_BITS-1:0] Y_MAX =
        (ACC_BITS'(1) <<< (SAMPLE_BITS - 1)) - ACC_BITS'(1);
    localparam logic signed [ACC_BITS-1:0] Y_MIN = ~Y_MAX;

    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [PROD_W-1:0]      prod_reg, prod_next;
    logic signed [ACC_BITS-1:0]    acc_reg, acc_next;
    logic signed [DELAY_BITS-1:0]  w_reg, w_next;
    logic signed [COEF_BITS-1:0]   coef_op;
    logic signed [DELAY_BITS-1:0]  data_op;
    logic signed [ACC_BITS-1:0]    prod_ext;
    logic signed [ACC_BITS-1:0]    x_ext;
    logic signed [ACC_BITS-1:0]    biased;
    logic signed [ACC_BITS-1:0]    shifted;

    // Operand select and multiply
    always_comb begin
        unique case (ctl.uc.coef_sel)
            CS_B0:   coef_op = b0;
            CS_B1:   coef_op = b1;
            CS_B2:   coef_op = b2;
            CS_A1:   coef_op = a1;
            CS_A2:   coef_op = a2;
            default: coef_op = '0;
        endcase
        unique case (ctl.uc.data_sel)
            DS_D1:   data_op = d1;
            DS_D2:   data_op = d2;
            DS_W:    data_op = w_reg;
            default: data_op = '0;
        endcase
        prod_next = PROD_W'(coef_op) * PROD_W'(data_op);
    end

    // Accumulate the registered product
    always_comb begin
        prod_ext = ACC_BITS'(prod_reg);
        x_ext    = ACC_BITS'(x_reg) <<< CFRAC;
        unique case (ctl.uc.acc_op)
            ACC_HOLD:   acc_next = acc_reg;
            ACC_LOAD_X: acc_next = x_ext;
            ACC_SUB_P:  acc_next = sat_addsub(acc_reg, prod_ext, 1'b1);
            ACC_ADD_P:  acc_next = sat_addsub(acc_reg, prod_ext, 1'b0);
            ACC_LOAD_P: acc_next = prod_ext;
            default:    acc_next = acc_reg;
        endcase
    end

    // Round half up, drop the coefficient fraction, then saturate
    always_comb begin
        biased  = sat_addsub(acc_reg, RND_BIAS, 1'b0);
        shifted = biased >>> CFRAC;
        if (shifted > W_MAX) begin
            w_next = W_MAX[DELAY_BITS-1:0];
        end else if (shifted < W_MIN) begin
            w_next = W_MIN[DELAY_BITS-1:0];
        end else begin
            w_next = shifted[DELAY_BITS-1:0];
        end
        if (shifted > Y_MAX) begin
            y_out = Y_MAX[SAMPLE_BITS-1:0];
        end else if (shifted < Y_MIN) begin
            y_out = Y_MIN[SAMPLE_BITS-1:0];
        end else begin
            y_out = shifted[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ld) begin
            x_reg <= x_in;
        end
        if (ctl.en) begin
            prod_reg <= prod_next;
            acc_reg  <= acc_next;
        end
        if (ctl.en && ctl.uc.w_ld) begin
            w_reg <= w_next;
        end
    end

    assign w_out = w_reg;

endmodule

// File: rtl/core/multichannel_biquad_filter.sv
// Multichannel direct-form-II biquad: coefficient registers, channel check,
// result register and assertions. Depends on mbq_pkg, mbq_seq, mbq_delay_ram,
// mbq_datapath and multichannel_biquad_filter_assert.svh.
//
// Usage:
//   Input requests carry one Q1.23 sample in s_tdata and its channel in s_tuser.
//   Each yields one result: filtered sample in m_tdata, channel and an error flag
//   in m_tuser. A channel at or above channels_in_use (or MAX_CHANNELS) gives
//   the error flag, a zero sample, and leaves the delays alone.
//   One request is in work at a time. A valid channel runs the seven-step
//   microcode program on one shared multiplier before m_tvalid rises, and
//   s_tready returns as m_tvalid rises. A flagged channel jumps from the
//   first step straight to the output step.
//   The result register lets a new request start while a result waits; a
//   stalled receiver holds the sequencer at its output step until m_tready.
//   Reset (aresetn low, synchronous) clears coefficients to zero, sets
//   channels_in_use to one and clears all delays. Any write to a listed
//   register also clears all delays; write configuration only while idle.
module multichannel_biquad_filter
    import mbq_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int COEF_BITS    = COEF_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,   // sample_in
    input  logic [CH_BITS-1:0]                  s_tuser,   // channel_index
    // Result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,   // sample_out
    output logic [CH_BITS:0]                    m_tuser,   // channel_out, channel_error
    // Configuration write port
    input  logic                                cfg_we,
    input  logic [CFG_ADDR_W-1:0]               cfg_addr,
    input  logic [COEF_BITS-1:0]                cfg_wdata
);

    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int ADDR_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic signed [COEF_BITS-1:0]   b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;
    logic [CH_USE_BITS-1:0]        ch_use_reg;
    logic [CH_BITS-1:0]            ch_reg;
    logic                          err_reg;
    logic                          err_next;
    logic                          m_valid_reg, m_valid_next;
    logic [CH_BITS-1:0]            out_ch_reg;
    logic [SAMPLE_BITS-1:0]        out_sample_reg;
    logic                          out_err_reg;
    logic                          accept;
    logic                          cfg_hit;
    logic                          out_ld_en;
    logic                          seq_busy;
    seq_ctl_t                      ctl;
    logic signed [DELAY_BITS-1:0]  d1, d2, w_val;
    logic signed [SAMPLE_BITS-1:0] y_val;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !seq_busy;
    assign cfg_hit  = cfg_we && (32'(cfg_addr) < 32'(NUM_REGS));
    assign err_next = ({1'b0, s_tuser} >= ch_use_reg) || (32'(s_tuser) >= 32'(MAX_CHANNELS));
    assign out_ld_en = ctl.en && ctl.uc.out_ld;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b0_reg     <= '0;
            b1_reg     <= '0;
            b2_reg     <= '0;
            a1_reg     <= '0;
            a2_reg     <= '0;
            ch_use_reg <= CH_USE_BITS'(1);
        end else if (cfg_we) begin
            unique case (reg_idx_t'(cfg_addr))
                REG_B0:     b0_reg     <= cfg_wdata;
                REG_B1:     b1_reg     <= cfg_wdata;
                REG_B2:     b2_reg     <= cfg_wdata;
                REG_A1:     a1_reg     <= cfg_wdata;
                REG_A2:     a2_reg     <= cfg_wdata;
                REG_CH_USE: ch_use_reg <= cfg_wdata[CH_USE_BITS-1:0];
                default:    ;
            endcase
        end
    end

    // Capture the request's channel and its check
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_reg <= 1'b0;
        end else if (accept) begin
            err_reg <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ch_reg <= s_tuser;
        end
    end

    mbq_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept),
        .err      (err_reg),
        .out_busy (m_valid_reg && !m_tready),
        .ctl      (ctl),
        .busy     (seq_busy)
    );

    mbq_delay_ram #(
        .DEPTH  (MAX_CHANNELS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (cfg_hit),
        .rd_en   (accept && !err_next),
        .rd_addr (ADDR_W'(s_tuser)),
        .wr_en   (ctl.en && ctl.uc.mem_wr),
        .wr_addr (ADDR_W'(ch_reg)),
        .wr_d1   (w_val),
        .wr_d2   (d1),
        .rd_d1   (d1),
        .rd_d2   (d2)
    );

    mbq_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_dp (
        .aclk  (aclk),
        .in_ld (accept),
        .x_in  (s_tdata[SAMPLE_BITS-1:0]),
        .b0    (b0_reg),
        .b1    (b1_reg),
        .b2    (b2_reg),
        .a1    (a1_reg),
        .a2    (a2_reg),
        .ctl   (ctl),
        .d1    (d1),
        .d2    (d2),
        .w_out (w_val),
        .y_out (y_val)
    );

    // Result register
    always_comb begin
        m_valid_next = m_valid_reg;
        priority if (out_ld_en) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ld_en) begin
            out_ch_reg     <= ch_reg;
            out_err_reg    <= err_reg;
            out_sample_reg <= err_reg ? '0 : y_val;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_W'(out_sample_reg);
    assign m_tuser  = {out_err_reg, out_ch_reg};

`include "multichannel_biquad_filter_assert.svh"

    `MBQ_ASSERT_NEXT(a_accept_starts, aclk, aresetn, accept, seq_busy, "accepted request did not start the sequencer")
    `MBQ_ASSERT_IMPL(a_out_no_overwrite, aclk, aresetn, out_ld_en, !m_valid_reg || m_tready, "result register overwritten")
    `MBQ_ASSERT_IMPL(a_err_no_write, aclk, aresetn, ctl.en && ctl.uc.mem_wr, !err_reg, "delay write for a flagged channel")
    `MBQ_ASSERT_IMPL(a_err_zero, aclk, aresetn, m_tvalid && m_tuser[CH_BITS], out_sample_reg == '0, "flagged result with nonzero sample")

endmodule
